>>> rtl/linear_ode_2x2_solution_coeffs_defines.svh
// Assertion macros for the ODE coefficient pipeline.
// Each expects clk and rst in scope.
`ifndef LINEAR_ODE_2X2_SOLUTION_COEFFS_DEFINES_SVH
`define LINEAR_ODE_2X2_SOLUTION_COEFFS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define LODE_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: check failed");

// Next-cycle implication
`define LODE_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: check failed");

`else

`define LODE_ASSERT_IMPL(name, pre, post)
`define LODE_ASSERT_NEXT(name, pre, post)

`endif

`endif

>>> rtl/lode_pkg.sv
`timescale 1ns / 1ps

package lode_pkg;

  // Fixed point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // Square root: magnitude of the discriminant and its root
  localparam int SQ_W     = 66;
  localparam int ROOT_W   = SQ_W / 2;
  localparam int SQRT_LAT = ROOT_W;

  // Divider: signed numerator and divisor, saturated quotient
  localparam int NUM_W   = 64;
  localparam int DEN_W   = DATA_W + 1;
  localparam int QUO_W   = DATA_W;
  localparam int DIV_LAT = QUO_W + 3;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_DECOUPLED = 2'd0,
    KIND_COMPLEX   = 2'd1,
    KIND_REPEATED  = 2'd2,
    KIND_DISTINCT  = 2'd3
  } kind_t;

  typedef struct packed {
    logic                     clip;
    logic signed [QUO_W-1:0]  quot;
  } div_res_t;

endpackage

>>> rtl/lode_in_if.sv
`timescale 1ns / 1ps

interface lode_in_if import lode_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  m11;
  logic signed [DATA_W-1:0]  m12;
  logic signed [DATA_W-1:0]  m21;
  logic signed [DATA_W-1:0]  m22;
  logic signed [DATA_W-1:0]  init_x;
  logic signed [DATA_W-1:0]  init_y;

  modport source (output valid, m11, m12, m21, m22, init_x, init_y, input ready);
  modport sink   (input valid, m11, m12, m21, m22, init_x, init_y, output ready);
endinterface

>>> rtl/lode_out_if.sv
`timescale 1ns / 1ps

interface lode_out_if import lode_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                case_kind;
  logic                      roles_swapped;
  logic signed [DATA_W-1:0]  root_first;
  logic signed [DATA_W-1:0]  root_second;
  logic signed [DATA_W-1:0]  ratio_one;
  logic signed [DATA_W-1:0]  ratio_two;
  logic signed [DATA_W-1:0]  const_one;
  logic signed [DATA_W-1:0]  const_two;
  logic                      saturated;

  modport source (output valid, case_kind, roles_swapped, root_first, root_second,
                  ratio_one, ratio_two, const_one, const_two, saturated,
                  input ready);
  modport sink   (input valid, case_kind, roles_swapped, root_first, root_second,
                  ratio_one, ratio_two, const_one, const_two, saturated,
                  output ready);
endinterface

>>> rtl/lode_sqrt.sv
`timescale 1ns / 1ps

// Pipelined floor square root, one result bit per stage.
module lode_sqrt import lode_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   mag,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;

  typedef struct packed {
    logic [SQ_W-1:0]   op;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] rt;
  } sq_step_t;

  sq_step_t st  [ROOT_W];
  sq_step_t nxt [ROOT_W];

  // Trial subtract of (root*4 + 1) per stage
  always_comb begin
    sq_step_t         src;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        src.op  = mag;
        src.rem = '0;
        src.rt  = '0;
      end else begin
        src = st[k-1];
      end
      sh    = {src.rem[REM_W-3:0], src.op[SQ_W-1:SQ_W-2]};
      trial = {1'b0, src.rt, 2'b01};
      nxt[k].op = {src.op[SQ_W-3:0], 2'b00};
      if (sh >= trial) begin
        nxt[k].rem = sh - trial;
        nxt[k].rt  = {src.rt[ROOT_W-2:0], 1'b1};
      end else begin
        nxt[k].rem = sh;
        nxt[k].rt  = {src.rt[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign root = st[ROOT_W-1].rt;

endmodule

>>> rtl/lode_div.sv
`timescale 1ns / 1ps

// Pipelined signed divider, truncating, saturated to QUO_W bits.
module lode_div import lode_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output div_res_t                res
);

  localparam int REM_W = DEN_W + 1;

  typedef struct packed {
    logic              neg;
    logic              nneg;
    logic              dz;
    logic              ovf;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  q;
    logic [DEN_W-1:0]  dmag;
  } dv_step_t;

  // Stage a: signs and magnitudes
  logic             a_neg;
  logic             a_nneg;
  logic             a_dz;
  logic [NUM_W-1:0] a_nmag;
  logic [DEN_W-1:0] a_dmag;

  always_ff @(posedge clk) begin
    if (en) begin
      a_nneg <= num[NUM_W-1];
      a_neg  <= num[NUM_W-1] ^ den[DEN_W-1];
      a_dz   <= (den == '0);
      a_nmag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      a_dmag <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    end
  end

  // Stage b: quotient range check and first remainder
  dv_step_t st  [QUO_W+1];
  dv_step_t nxt [QUO_W+1];

  always_comb begin
    logic [REM_W-1:0] sh;
    nxt[0].neg  = a_neg;
    nxt[0].nneg = a_nneg;
    nxt[0].dz   = a_dz;
    nxt[0].ovf  = ({1'b0, a_nmag} >= {a_dmag, {QUO_W{1'b0}}});
    nxt[0].rem  = REM_W'(a_nmag[NUM_W-1:QUO_W]);
    nxt[0].low  = a_nmag[QUO_W-1:0];
    nxt[0].q    = '0;
    nxt[0].dmag = a_dmag;
    // One quotient bit per stage
    for (int k = 1; k <= QUO_W; k++) begin
      nxt[k] = st[k-1];
      sh = {st[k-1].rem[REM_W-2:0], st[k-1].low[QUO_W-1]};
      nxt[k].low = {st[k-1].low[QUO_W-2:0], 1'b0};
      if (sh >= {1'b0, st[k-1].dmag}) begin
        nxt[k].rem = sh - {1'b0, st[k-1].dmag};
        nxt[k].q   = {st[k-1].q[QUO_W-2:0], 1'b1};
      end else begin
        nxt[k].rem = sh;
        nxt[k].q   = {st[k-1].q[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QUO_W; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Final stage: sign, zero divisor and saturation
  div_res_t res_next;

  always_comb begin
    dv_step_t f;
    f = st[QUO_W];
    res_next.clip = 1'b0;
    res_next.quot = '0;
    if (f.dz) begin
      res_next.clip = 1'b1;
      res_next.quot = f.nneg ? Q_MIN : Q_MAX;
    end else if (f.ovf) begin
      res_next.clip = 1'b1;
      res_next.quot = f.neg ? Q_MIN : Q_MAX;
    end else if (!f.neg) begin
      res_next.clip = f.q[QUO_W-1];
      res_next.quot = f.q[QUO_W-1] ? Q_MAX : $signed(f.q);
    end else if (f.q > QUO_W'(Q_MIN)) begin
      res_next.clip = 1'b1;
      res_next.quot = Q_MIN;
    end else begin
      res_next.quot = $signed(-f.q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/linear_ode_2x2_solution_coeffs.sv
// Stages from an accepted request to its result
//   (2 front stages, 33-stage square root, 2 stages, 35-stage divider,
//   2 stages, 35-stage divider, output register).
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, clears the valid bits of every stage; data is not reset.
`timescale 1ns / 1ps
`include "linear_ode_2x2_solution_coeffs_defines.svh"

module linear_ode_2x2_solution_coeffs import lode_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lode_in_if.sink    sys,
  lode_out_if.source sol
);

  typedef struct packed {
    kind_t                    kind;
    logic                     swap;
    logic signed [DATA_W:0]   t;
    logic signed [DATA_W-1:0] diag;
    logic signed [DATA_W-1:0] off;
    logic signed [DATA_W-1:0] v1;
    logic signed [DATA_W-1:0] v2;
    logic signed [DATA_W-1:0] m22;
    logic signed [DATA_W-1:0] r1;
    logic signed [DATA_W-1:0] r2;
    logic signed [DATA_W-1:0] q1;
    logic signed [DATA_W-1:0] q2;
    logic                     sat;
  } ctx_t;

  // Saturate to DATA_W bits; returns {flag, value}
  function automatic logic [DATA_W:0] sat32(input logic signed [35:0] v);
    logic [DATA_W:0] r;
    if (v > 36'(Q_MAX))      r = {1'b1, Q_MAX};
    else if (v < 36'(Q_MIN)) r = {1'b1, Q_MIN};
    else                     r = {1'b0, v[DATA_W-1:0]};
    return r;
  endfunction

  logic adv;
  assign adv       = !sol.valid || sol.ready;
  assign sys.ready = adv;

  // Stage 1: routing, trace and products
  logic                     s1_vld;
  ctx_t                     s1_ctx;
  logic [2*DATA_W:0]        s1_u2;
  logic signed [2*DATA_W-1:0] s1_p;

  logic                     dec;
  logic                     swp;
  logic signed [DATA_W:0]   u;
  logic signed [2*DATA_W+1:0] u2_full;
  ctx_t                     s1_next;

  always_comb begin
    dec = (sys.m12 == '0) && (sys.m21 == '0);
    swp = (sys.m12 == '0) && !dec;
    u   = {sys.m11[DATA_W-1], sys.m11} - {sys.m22[DATA_W-1], sys.m22};
    u2_full = u * u;
    s1_next      = '0;
    s1_next.kind = KIND_DECOUPLED;
    s1_next.swap = swp;
    s1_next.t    = {sys.m11[DATA_W-1], sys.m11} + {sys.m22[DATA_W-1], sys.m22};
    s1_next.diag = swp ? sys.m22 : sys.m11;
    s1_next.off  = swp ? sys.m21 : sys.m12;
    s1_next.v1   = swp ? sys.init_y : sys.init_x;
    s1_next.v2   = swp ? sys.init_x : sys.init_y;
    s1_next.m22  = sys.m22;
    s1_next.sat  = dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= sys.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctx <= s1_next;
      s1_u2  <= u2_full[2*DATA_W:0];
      s1_p   <= sys.m12 * sys.m21;
    end
  end

  // Stage 2: discriminant sign and magnitude (sat carries the decoupled mark here)
  logic               s2_vld;
  ctx_t               s2_ctx;
  logic [SQ_W-1:0]    s2_mag;
  logic signed [66:0] d_val;
  ctx_t               s2_next;

  always_comb begin
    d_val = $signed({2'b00, s1_u2}) + ($signed({{3{s1_p[2*DATA_W-1]}}, s1_p}) <<< 2);
    s2_next     = s1_ctx;
    s2_next.sat = 1'b0;
    if (s1_ctx.sat)             s2_next.kind = KIND_DECOUPLED;
    else if (d_val[66])         s2_next.kind = KIND_COMPLEX;
    else if (d_val == '0)       s2_next.kind = KIND_REPEATED;
    else                        s2_next.kind = KIND_DISTINCT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctx <= s2_next;
      s2_mag <= d_val[66] ? SQ_W'(-d_val) : SQ_W'(d_val);
    end
  end

  // Square root, context travels alongside
  logic [ROOT_W-1:0]   sq_root;
  ctx_t                sq_ctx [SQRT_LAT];
  logic [SQRT_LAT-1:0] sq_vld;

  lode_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .mag  (s2_mag),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else if (adv) begin
      sq_vld <= {sq_vld[SQRT_LAT-2:0], s2_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ctx[0] <= s2_ctx;
      for (int i = 1; i < SQRT_LAT; i++) begin
        sq_ctx[i] <= sq_ctx[i-1];
      end
    end
  end

  // Stage 3: roots
  logic         s3_vld;
  ctx_t         s3_ctx;
  ctx_t         s3_next;
  ctx_t         sq_last;
  logic signed [34:0] t35;
  logic signed [34:0] r35;
  logic signed [34:0] sum35;
  logic signed [34:0] dif35;
  logic signed [35:0] half_t;
  logic signed [35:0] half_sum;
  logic signed [35:0] half_dif;
  logic signed [35:0] half_rt;
  logic [DATA_W:0]    st_r1;
  logic [DATA_W:0]    st_r2;

  always_comb begin
    sq_last  = sq_ctx[SQRT_LAT-1];
    t35      = {{2{sq_last.t[DATA_W]}}, sq_last.t};
    r35      = {{(35-ROOT_W){1'b0}}, sq_root};
    sum35    = t35 + r35;
    dif35    = t35 - r35;
    // halve with truncation toward zero
    half_t   = $signed({t35[34], t35} + 36'(t35[34])) >>> 1;
    half_sum = $signed({sum35[34], sum35} + 36'(sum35[34])) >>> 1;
    half_dif = $signed({dif35[34], dif35} + 36'(dif35[34])) >>> 1;
    half_rt  = {1'b0, r35} >>> 1;
    s3_next  = sq_last;
    st_r1    = sat32(half_t);
    st_r2    = '0;
    unique case (sq_last.kind)
      KIND_COMPLEX:  st_r2 = sat32(half_rt);
      KIND_DISTINCT: begin
        st_r1 = sat32(half_sum);
        st_r2 = sat32(half_dif);
      end
      default: st_r2 = '0;
    endcase
    s3_next.r1  = st_r1[DATA_W-1:0];
    s3_next.r2  = st_r2[DATA_W-1:0];
    s3_next.sat = st_r1[DATA_W] | st_r2[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= sq_vld[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctx <= s3_next;
    end
  end

  // Stage 4: ratio numerators
  logic                    s4_vld;
  ctx_t                    s4_ctx;
  logic signed [NUM_W-1:0] s4_n1;
  logic signed [NUM_W-1:0] s4_n2;
  logic signed [DEN_W-1:0] s4_den;
  logic signed [DATA_W:0]  d1;
  logic signed [DATA_W:0]  d2;
  logic signed [NUM_W-1:0] n2_next;

  always_comb begin
    d1 = {s3_ctx.r1[DATA_W-1], s3_ctx.r1} - {s3_ctx.diag[DATA_W-1], s3_ctx.diag};
    d2 = {s3_ctx.r2[DATA_W-1], s3_ctx.r2} - {s3_ctx.diag[DATA_W-1], s3_ctx.diag};
    unique case (s3_ctx.kind)
      KIND_COMPLEX:  n2_next = $signed({{(NUM_W-DATA_W){s3_ctx.r2[DATA_W-1]}}, s3_ctx.r2})
                               <<< FRAC_BITS;
      KIND_REPEATED: n2_next = $signed(NUM_W'(1)) <<< (2 * FRAC_BITS);
      default:       n2_next = $signed({{(NUM_W-DATA_W-1){d2[DATA_W]}}, d2}) <<< FRAC_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ctx <= s3_ctx;
      s4_n1  <= $signed({{(NUM_W-DATA_W-1){d1[DATA_W]}}, d1}) <<< FRAC_BITS;
      s4_n2  <= n2_next;
      s4_den <= {s3_ctx.off[DATA_W-1], s3_ctx.off};
    end
  end

  // Ratio dividers
  div_res_t           dv1_res;
  div_res_t           dv2_res;
  ctx_t               d1_ctx [DIV_LAT];
  logic [DIV_LAT-1:0] d1_vld;

  lode_div u_div_s1 (
    .clk (clk),
    .en  (adv),
    .num (s4_n1),
    .den (s4_den),
    .res (dv1_res)
  );

  lode_div u_div_s2 (
    .clk (clk),
    .en  (adv),
    .num (s4_n2),
    .den (s4_den),
    .res (dv2_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= '0;
    end else if (adv) begin
      d1_vld <= {d1_vld[DIV_LAT-2:0], s4_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_ctx[0] <= s4_ctx;
      for (int i = 1; i < DIV_LAT; i++) begin
        d1_ctx[i] <= d1_ctx[i-1];
      end
    end
  end

  // Stage 5: product for the constant numerator, divisor for the constants
  logic                     s5_vld;
  ctx_t                     s5_ctx;
  ctx_t                     s5_next;
  logic signed [2*DATA_W-1:0] s5_prod;
  logic signed [DEN_W-1:0]  s5_den;
  logic signed [DATA_W-1:0] qsel;
  logic signed [DEN_W-1:0]  den_next;

  always_comb begin
    s5_next     = d1_ctx[DIV_LAT-1];
    s5_next.q1  = dv1_res.quot;
    s5_next.q2  = dv2_res.quot;
    s5_next.sat = s5_next.sat | dv1_res.clip | dv2_res.clip;
    if (s5_next.kind == KIND_DISTINCT) begin
      qsel     = dv2_res.quot;
      den_next = {dv1_res.quot[DATA_W-1], dv1_res.quot}
               - {dv2_res.quot[DATA_W-1], dv2_res.quot};
    end else begin
      qsel     = dv1_res.quot;
      den_next = {dv2_res.quot[DATA_W-1], dv2_res.quot};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= d1_vld[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_ctx  <= s5_next;
      s5_prod <= qsel * s5_next.v1;
      s5_den  <= den_next;
    end
  end

  // Stage 6: constant numerator
  logic                    s6_vld;
  ctx_t                    s6_ctx;
  logic signed [NUM_W-1:0] s6_num;
  logic signed [DEN_W-1:0] s6_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_ctx <= s5_ctx;
      s6_num <= ($signed({{(NUM_W-DATA_W){s5_ctx.v2[DATA_W-1]}}, s5_ctx.v2}) <<< FRAC_BITS)
              - NUM_W'(s5_prod);
      s6_den <= s5_den;
    end
  end

  // Constant divider
  div_res_t           dvc_res;
  ctx_t               d2_ctx [DIV_LAT];
  logic [DIV_LAT-1:0] d2_vld;

  lode_div u_div_c (
    .clk (clk),
    .en  (adv),
    .num (s6_num),
    .den (s6_den),
    .res (dvc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_vld <= '0;
    end else if (adv) begin
      d2_vld <= {d2_vld[DIV_LAT-2:0], s6_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_ctx[0] <= s6_ctx;
      for (int i = 1; i < DIV_LAT; i++) begin
        d2_ctx[i] <= d2_ctx[i-1];
      end
    end
  end

  // Stage 7: result assembly into the output register
  ctx_t                     fin;
  logic [DATA_W:0]          st_c2;
  logic signed [DATA_W-1:0] c1_next;
  logic signed [DATA_W-1:0] c2_next;
  logic signed [DATA_W-1:0] r1_out;
  logic signed [DATA_W-1:0] r2_out;
  logic signed [DATA_W-1:0] q1_out;
  logic signed [DATA_W-1:0] q2_out;
  logic                     sat_next;

  always_comb begin
    fin    = d2_ctx[DIV_LAT-1];
    st_c2  = sat32(36'($signed({fin.v1[DATA_W-1], fin.v1}))
                 - 36'($signed({dvc_res.quot[DATA_W-1], dvc_res.quot})));
    r1_out   = fin.r1;
    r2_out   = fin.r2;
    q1_out   = fin.q1;
    q2_out   = fin.q2;
    c1_next  = fin.v1;
    c2_next  = dvc_res.quot;
    sat_next = fin.sat | dvc_res.clip;
    unique case (fin.kind)
      KIND_DECOUPLED: begin
        r1_out   = fin.diag;
        r2_out   = fin.m22;
        q1_out   = '0;
        q2_out   = '0;
        c2_next  = fin.v2;
        sat_next = 1'b0;
      end
      KIND_DISTINCT: begin
        c1_next  = dvc_res.quot;
        c2_next  = st_c2[DATA_W-1:0];
        sat_next = fin.sat | dvc_res.clip | st_c2[DATA_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sol.valid <= 1'b0;
    end else if (adv) begin
      sol.valid <= d2_vld[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sol.case_kind     <= fin.kind;
      sol.roles_swapped <= fin.swap;
      sol.root_first    <= r1_out;
      sol.root_second   <= r2_out;
      sol.ratio_one     <= q1_out;
      sol.ratio_two     <= q2_out;
      sol.const_one     <= c1_next;
      sol.const_two     <= c2_next;
      sol.saturated     <= sat_next;
    end
  end

  // Checks
  `LODE_ASSERT_IMPL(a_decoupled_clean,
    sol.valid && (sol.case_kind == KIND_DECOUPLED),
    !sol.saturated && (sol.ratio_one == '0) && (sol.ratio_two == '0))
  `LODE_ASSERT_IMPL(a_repeated_no_second,
    sol.valid && (sol.case_kind == KIND_REPEATED),
    sol.root_second == '0)
  `LODE_ASSERT_NEXT(a_request_enters,
    sys.valid && sys.ready,
    s1_vld)

endmodule
